### rtl/vdptr_pkg.sv
// Package with the shared constants, types and tables of the text render and dither block.
package vdptr_pkg;

    // Video memory geometry. The pointer and all memory addresses are 17 bits wide.
    localparam int VA_W      = 17;
    localparam int VRAM_SIZE = 1 << VA_W;
    localparam int PTR_LOW_W = 14;

    // Number of implemented control registers.
    localparam int REG_COUNT = 47;

    // Command codes of an input transaction.
    localparam int          CMD_W     = 2;
    localparam logic [1:0]  CMD_READ  = 2'd0;
    localparam logic [1:0]  CMD_WRITE = 2'd1;
    localparam logic [1:0]  CMD_PIXEL = 2'd2;

    // Port addresses on the bus.
    localparam logic [15:0] PORT_DATA     = 16'hFF78;
    localparam logic [15:0] PORT_CTRL     = 16'hFF79;
    localparam logic [15:0] PORT_INDIRECT = 16'hFF7B;

    // Register numbers that have an effect.
    localparam logic [5:0] REG_NAME_BASE = 6'd2;
    localparam logic [5:0] REG_PAT_BASE  = 6'd4;
    localparam logic [5:0] REG_COLOR     = 6'd7;
    localparam logic [5:0] REG_PTR_HIGH  = 6'd14;
    localparam logic [5:0] REG_INDIRECT  = 6'd17;

    // Text window: 80 columns of 6-pixel glyphs centered on a 640-pixel line.
    localparam int TEXT_LEFT  = 80;
    localparam int TEXT_RIGHT = 560;
    localparam int TEXT_LINES = 212;

    // floor(tx * 171 / 1024) equals floor(tx / 6) for every tx below 480.
    localparam int DIV6_MUL = 171;

    // Per-pixel context handed from the fetch pipeline to the color stage.
    typedef struct packed {
        logic [2:0] glyph_col;
        logic [3:0] fg;
        logic [3:0] bg;
        logic [1:0] row;
        logic [1:0] col;
    } t_px_ctx;

    // One result transaction.
    typedef struct packed {
        logic       is_pixel;
        logic [7:0] read_data;
        logic [2:0] pixel_rgb;
    } t_result;

    // Default palette, 3 bits per channel packed as 0RRR0GGG0BBB.
    function automatic logic [11:0] palette_color(input logic [3:0] idx);
        logic [11:0] c;
        case (idx)
            4'd0:    c = 12'h000;
            4'd1:    c = 12'h000;
            4'd2:    c = 12'h021;
            4'd3:    c = 12'h032;
            4'd4:    c = 12'h011;
            4'd5:    c = 12'h113;
            4'd6:    c = 12'h200;
            4'd7:    c = 12'h133;
            4'd8:    c = 12'h300;
            4'd9:    c = 12'h311;
            4'd10:   c = 12'h330;
            4'd11:   c = 12'h332;
            4'd12:   c = 12'h020;
            4'd13:   c = 12'h213;
            4'd14:   c = 12'h222;
            default: c = 12'h333;
        endcase
        return c;
    endfunction

    // 4x4 ordered dither thresholds, indexed by line and column modulo 4.
    function automatic logic [3:0] dither_threshold(input logic [1:0] row,
                                                    input logic [1:0] col);
        logic [3:0] t;
        case ({row, col})
            4'h0:    t = 4'd0;
            4'h1:    t = 4'd8;
            4'h2:    t = 4'd2;
            4'h3:    t = 4'd10;
            4'h4:    t = 4'd12;
            4'h5:    t = 4'd4;
            4'h6:    t = 4'd14;
            4'h7:    t = 4'd6;
            4'h8:    t = 4'd3;
            4'h9:    t = 4'd11;
            4'hA:    t = 4'd1;
            4'hB:    t = 4'd9;
            4'hC:    t = 4'd15;
            4'hD:    t = 4'd7;
            4'hE:    t = 4'd13;
            default: t = 4'd5;
        endcase
        return t;
    endfunction

endpackage

### rtl/vdptr_ifs.sv
// Valid/ready channel interfaces for the input and result transactions.
interface vdptr_in_if;
    logic                        valid;
    logic                        ready;
    logic [vdptr_pkg::CMD_W-1:0] cmd;
    logic [15:0]                 port_addr;
    logic [7:0]                  write_byte;
    logic [15:0]                 scan_line;
    logic [9:0]                  pixel_x;

    modport source (output valid, cmd, port_addr, write_byte, scan_line, pixel_x,
                    input ready);
    modport sink   (input valid, cmd, port_addr, write_byte, scan_line, pixel_x,
                    output ready);
endinterface

interface vdptr_out_if;
    logic       valid;
    logic       ready;
    logic       is_pixel;
    logic [7:0] read_data;
    logic [2:0] pixel_rgb;

    modport source (output valid, is_pixel, read_data, pixel_rgb, input ready);
    modport sink   (input valid, is_pixel, read_data, pixel_rgb, output ready);
endinterface

### rtl/vdp_ports_text_render_dither.sv
// Top level: CPU ports and 80-column text pixel renderer around one shared video memory.
// Each port read and each pixel gives one result; writes give none. Port writes are taken
// one per cycle while input ready is high; port reads and border pixels can be taken before
// the last one leaves stage A, as the two-entry result queue allows. A text pixel needs two
// dependent reads of the single memory read port; no transaction is taken during the second.
// Reset clears the control state and then sweeps the 131072-byte video memory to zero, one
// byte per cycle, so input ready stays low until the sweep is done.
module vdp_ports_text_render_dither (
    input logic           i_clk,
    input logic           i_rst_n,
    vdptr_in_if.sink      i_in,
    vdptr_out_if.source   o_out
);
    import vdptr_pkg::*;

    // Clearing sweep.
    logic            r_clearing;
    logic [VA_W-1:0] r_clr_addr;

    // Port state and the control registers that the renderer and ports use.
    // The other registers are written nowhere visible and need no storage.
    logic [VA_W-1:0] r_ptr, n_ptr;
    logic [7:0]      r_latch, n_latch;
    logic            r_latch_full, n_latch_full;
    logic [7:0]      r_reg_name, n_reg_name;
    logic [7:0]      r_reg_pat, n_reg_pat;
    logic [7:0]      r_reg_color, n_reg_color;
    logic [7:0]      r_reg_ind, n_reg_ind;

    // Stage A: the first memory read of a transaction is in flight.
    logic            r_a_valid;
    logic            r_a_fetch;      // a text pixel that still needs its font byte
    logic            r_a_from_ram;   // a data port read
    logic            r_a_is_pixel;
    logic [2:0]      r_a_border_rgb;
    logic [VA_W-1:0] r_font_off;
    t_px_ctx         r_px;

    // Stage B: the font byte read of a text pixel is in flight.
    logic            r_b_valid;

    // Two-entry result queue.
    t_result         r_q [2];
    logic            r_q_wr;
    logic            r_q_rd;
    logic [1:0]      r_q_count;

    // Decode of the incoming transaction.
    logic            acc;
    logic            ready;
    logic            cmd_read, cmd_write, cmd_pixel;
    logic            is_data, is_ctrl, is_ind;
    logic            border;
    logic [9:0]      tx_full;
    logic [8:0]      tx;
    logic [16:0]     col_prod;
    logic [6:0]      col;
    logic [8:0]      col6;
    logic [8:0]      rem_full;
    logic [11:0]     row_off;
    logic [VA_W-1:0] name_addr;
    t_px_ctx         px_in;

    // Register write path shared by the control and indirect ports.
    logic            put_en;
    logic [5:0]      put_idx;
    logic [7:0]      put_val;

    // Memory port.
    logic            ram_we;
    logic [VA_W-1:0] ram_waddr;
    logic [7:0]      ram_wdata;
    logic            ram_re;
    logic [VA_W-1:0] ram_raddr;
    logic [7:0]      ram_rdata;

    // Result path.
    logic            inflight;
    logic            push;
    logic            pop;
    t_result         push_data;
    logic [2:0]      dither_rgb;

    assign acc       = i_in.valid && i_in.ready;
    assign cmd_read  = i_in.cmd == CMD_READ;
    assign cmd_write = i_in.cmd == CMD_WRITE;
    assign cmd_pixel = i_in.cmd == CMD_PIXEL;
    assign is_data   = i_in.port_addr == PORT_DATA;
    assign is_ctrl   = i_in.port_addr == PORT_CTRL;
    assign is_ind    = i_in.port_addr == PORT_INDIRECT;

    assign border = (i_in.pixel_x < 10'(TEXT_LEFT)) || (i_in.pixel_x >= 10'(TEXT_RIGHT))
                 || (i_in.scan_line >= 16'(TEXT_LINES));

    // Character cell address. Inside the window tx is below 480 and the line below 212,
    // so the divide by 6 is a reciprocal multiply and the divide by 8 a bit slice.
    assign tx_full  = i_in.pixel_x - 10'(TEXT_LEFT);
    assign tx       = tx_full[8:0];
    assign col_prod = 17'(tx) * 17'(DIV6_MUL);
    assign col      = col_prod[16:10];
    assign col6     = {col, 2'b00} + {1'b0, col, 1'b0};
    assign rem_full = tx - col6;
    assign row_off  = 12'({i_in.scan_line[7:3], 6'b0}) + 12'({i_in.scan_line[7:3], 4'b0});
    assign name_addr = {r_reg_name[6:0], 10'b0} + VA_W'(row_off) + VA_W'(col);

    assign px_in.glyph_col = rem_full[2:0];
    assign px_in.fg        = r_reg_color[7:4];
    assign px_in.bg        = r_reg_color[3:0];
    assign px_in.row       = i_in.scan_line[1:0];
    assign px_in.col       = i_in.pixel_x[1:0];

    // A new transaction needs the read port free in the same cycle and room for its result;
    // an item in flight and the queued results together never exceed the queue depth.
    assign inflight = r_a_valid || r_b_valid;
    assign ready = !r_clearing && !(r_a_valid && r_a_fetch)
                && ((r_q_count == 2'd0) || ((r_q_count == 2'd1) && !inflight));
    assign i_in.ready = ready;

    // Port side effects on pointer, latch and control registers.
    always_comb begin
        n_ptr        = r_ptr;
        n_latch      = r_latch;
        n_latch_full = r_latch_full;
        n_reg_name   = r_reg_name;
        n_reg_pat    = r_reg_pat;
        n_reg_color  = r_reg_color;
        n_reg_ind    = r_reg_ind;
        put_en       = 1'b0;
        put_idx      = r_reg_ind[5:0];
        put_val      = i_in.write_byte;

        if (acc && cmd_read && is_data) begin
            n_ptr = r_ptr + VA_W'(1);
        end

        if (acc && cmd_write) begin
            if (is_data) begin
                n_ptr = r_ptr + VA_W'(1);
            end else if (is_ctrl) begin
                if (!r_latch_full) begin
                    n_latch      = i_in.write_byte;
                    n_latch_full = 1'b1;
                end else begin
                    n_latch_full = 1'b0;
                    if (!i_in.write_byte[7]) begin
                        n_ptr = {r_ptr[VA_W-1:PTR_LOW_W], i_in.write_byte[5:0], r_latch};
                    end else begin
                        put_en  = 1'b1;
                        put_idx = i_in.write_byte[5:0];
                        put_val = r_latch;
                    end
                end
            end else if (is_ind) begin
                put_en = 1'b1;
            end
        end

        if (put_en && ({1'b0, put_idx} < 7'(REG_COUNT))) begin
            case (put_idx)
                REG_NAME_BASE: n_reg_name  = put_val;
                REG_PAT_BASE:  n_reg_pat   = put_val;
                REG_COLOR:     n_reg_color = put_val;
                REG_INDIRECT:  n_reg_ind   = put_val;
                REG_PTR_HIGH:  n_ptr = {put_val[VA_W-PTR_LOW_W-1:0], r_ptr[PTR_LOW_W-1:0]};
                default:       ;
            endcase
        end

        // The indirect register steps on unless its own hold bit is now set.
        if (acc && cmd_write && is_ind && !n_reg_ind[7]) begin
            n_reg_ind = {2'b00, r_reg_ind[5:0] + 6'd1};
        end
    end

    // Memory port arbitration: the sweep owns the write port after reset; a font fetch
    // in stage A owns the read port, which is why no transaction is taken in that cycle.
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_ptr;
        ram_wdata = i_in.write_byte;
        if (r_clearing) begin
            ram_we    = 1'b1;
            ram_waddr = r_clr_addr;
            ram_wdata = 8'h00;
        end else if (acc && cmd_write && is_data) begin
            ram_we = 1'b1;
        end
    end

    always_comb begin
        ram_re    = 1'b0;
        ram_raddr = r_ptr;
        if (r_a_valid && r_a_fetch) begin
            ram_re    = 1'b1;
            ram_raddr = r_font_off + {{(VA_W-11){1'b0}}, ram_rdata, 3'b000};
        end else if (acc && cmd_read && is_data) begin
            ram_re = 1'b1;
        end else if (acc && cmd_pixel && !border) begin
            ram_re    = 1'b1;
            ram_raddr = name_addr;
        end
    end

    vdptr_ram #(
        .WIDTH (8),
        .DEPTH (VRAM_SIZE)
    ) u_vram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // In stage B the memory output is the font byte of the pixel.
    vdptr_dither u_dither (
        .i_font (ram_rdata),
        .i_ctx  (r_px),
        .o_rgb  (dither_rgb)
    );

    // Stages A and B never hold a transaction at the same time, so one queue write
    // per cycle suffices.
    assign push = r_b_valid || (r_a_valid && !r_a_fetch);
    assign pop  = o_out.valid && o_out.ready;

    always_comb begin
        if (r_b_valid) begin
            push_data.is_pixel  = 1'b1;
            push_data.read_data = 8'h00;
            push_data.pixel_rgb = dither_rgb;
        end else begin
            push_data.is_pixel  = r_a_is_pixel;
            push_data.read_data = r_a_from_ram ? ram_rdata : 8'h00;
            push_data.pixel_rgb = r_a_is_pixel ? r_a_border_rgb : 3'b000;
        end
    end

    assign o_out.valid     = r_q_count != 2'd0;
    assign o_out.is_pixel  = r_q[r_q_rd].is_pixel;
    assign o_out.read_data = r_q[r_q_rd].read_data;
    assign o_out.pixel_rgb = r_q[r_q_rd].pixel_rgb;

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing   <= 1'b1;
            r_clr_addr   <= '0;
            r_ptr        <= '0;
            r_latch      <= '0;
            r_latch_full <= 1'b0;
            r_reg_name   <= '0;
            r_reg_pat    <= '0;
            r_reg_color  <= '0;
            r_reg_ind    <= '0;
            r_a_valid    <= 1'b0;
            r_b_valid    <= 1'b0;
            r_q_wr       <= 1'b0;
            r_q_rd       <= 1'b0;
            r_q_count    <= '0;
        end else begin
            if (r_clearing) begin
                r_clr_addr <= r_clr_addr + VA_W'(1);
                if (r_clr_addr == VA_W'(VRAM_SIZE - 1)) begin
                    r_clearing <= 1'b0;
                end
            end
            r_ptr        <= n_ptr;
            r_latch      <= n_latch;
            r_latch_full <= n_latch_full;
            r_reg_name   <= n_reg_name;
            r_reg_pat    <= n_reg_pat;
            r_reg_color  <= n_reg_color;
            r_reg_ind    <= n_reg_ind;
            r_a_valid    <= acc && (cmd_read || cmd_pixel);
            r_b_valid    <= r_a_valid && r_a_fetch;
            if (push) begin
                r_q_wr <= ~r_q_wr;
            end
            if (pop) begin
                r_q_rd <= ~r_q_rd;
            end
            r_q_count <= r_q_count + {1'b0, push} - {1'b0, pop};
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_a_fetch      <= cmd_pixel && !border;
            r_a_from_ram   <= cmd_read && is_data;
            r_a_is_pixel   <= cmd_pixel;
            r_a_border_rgb <= r_reg_color[2:0];
        end
        if (acc && cmd_pixel) begin
            r_px       <= px_in;
            r_font_off <= {r_reg_pat[5:0], 8'b0, i_in.scan_line[2:0]};
        end
        if (push) begin
            r_q[r_q_wr] <= push_data;
        end
    end

    // The two fetch stages are never occupied together.
    a_stage_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_a_valid && r_b_valid))
        else $error("fetch stages A and B both occupied");

    // A font fetch only follows a character code fetch.
    a_font_follows_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_b_valid |-> $past(r_a_valid && r_a_fetch))
        else $error("font fetch without a preceding character fetch");

    // A result never arrives at a full queue.
    a_queue_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> (r_q_count != 2'd2))
        else $error("result queue overflow");

    // The clearing sweep never shares the memory with a read.
    a_clear_no_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clearing |-> !ram_re)
        else $error("memory read during clearing sweep");

    // A data port read advances the pointer by one.
    a_ptr_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && cmd_read && is_data) |=> (r_ptr == $past(r_ptr) + VA_W'(1)))
        else $error("pointer did not advance after a data read");
endmodule

### rtl/vdptr_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read.
module vdptr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

### rtl/vdptr_dither.sv
// Glyph bit selection, palette lookup and ordered dither of one text pixel.
module vdptr_dither (
    input  logic               [7:0] i_font,
    input  vdptr_pkg::t_px_ctx       i_ctx,
    output logic               [2:0] o_rgb
);
    import vdptr_pkg::*;

    logic        on;
    logic [11:0] color;
    logic [3:0]  thr;

    // The leftmost glyph column is the most significant font bit.
    assign on    = i_font[3'd7 - i_ctx.glyph_col];
    assign color = palette_color(on ? i_ctx.fg : i_ctx.bg);
    assign thr   = dither_threshold(i_ctx.row, i_ctx.col);

    // A channel lights when twice its level plus the threshold exceeds 15.
    assign o_rgb[2] = ({1'b0, color[10:8], 1'b0} + {1'b0, thr}) > 5'd15;
    assign o_rgb[1] = ({1'b0, color[6:4], 1'b0} + {1'b0, thr}) > 5'd15;
    assign o_rgb[0] = ({1'b0, color[2:0], 1'b0} + {1'b0, thr}) > 5'd15;
endmodule
